// ===== rtl/core/min_tracking_stack_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the minimum-tracking stack
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_TOP_ASSERT_SVH
`define MIN_TRACKING_STACK_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MSK_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MSK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/msk_pkg.sv =====
// ----------------------------------------------------------------------------
// Minimum-tracking stack package
// Sizes, operation codes and state type shared by the stack and its checker.
// ----------------------------------------------------------------------------
package msk_pkg;

	localparam int STACK_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int IN_W        = 40;
	localparam int OUT_W       = 80;
	localparam int COUNT_W     = 11;

	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_LOAD
	} state_t;

endpackage

// ===== rtl/core/min_tracking_stack_top.sv =====
// ----------------------------------------------------------------------------
// Minimum-tracking stack
// LIFO of signed 32-bit values that also reports the least value it holds.
// ----------------------------------------------------------------------------
// The input stream carries one operation per transfer: push a value, pop, or
// query. Every input transfer yields exactly one output transfer with the top
// value, the minimum, an empty flag, a refused-push flag and the entry count.
// Values live in one memory and the running minima in a second memory, both
// with registered read data that is valid in the cycle after the address is
// presented; the current tops are also held in registers.
// A push, a query or a pop on an empty stack produces its result in the
// output register in the cycle after the input transfer, so these operations
// run at one transfer per cycle while the receiver takes results.
// A pop on a non-empty stack passes through ST_LOAD to read the new tops back
// from the memories, so no new transfer is taken until ST_LOAD is left.
// Reset clears both counts and the output valid flag; the stack is empty and
// usable in the first cycle after reset, with no clearing pass.
// While the receiver stalls, the result waits in the output register and a new
// input transfer is taken in the same cycle that the waiting result leaves.
// ----------------------------------------------------------------------------
module min_tracking_stack_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// mode[1:0], value[33:2], zero padding[39:34]
	input  logic [msk_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// top_value[31:0], min_value[63:32], is_empty[64], push_refused[65],
	// entry_count[76:66], zero padding[79:77]
	output logic [msk_pkg::OUT_W-1:0]  m_tdata
);

	logic [msk_pkg::DATA_W-1:0] val_mem [msk_pkg::STACK_DEPTH];
	logic [msk_pkg::DATA_W-1:0] min_mem [msk_pkg::STACK_DEPTH];

	msk_pkg::state_t state_q, state_d;

	logic [msk_pkg::CNT_W-1:0]  vcnt_q, vcnt_d;
	logic [msk_pkg::CNT_W-1:0]  mcnt_q, mcnt_d;
	logic signed [msk_pkg::DATA_W-1:0] top_q, top_d;
	logic signed [msk_pkg::DATA_W-1:0] min_q, min_d;
	logic [msk_pkg::DATA_W-1:0] vrd_q, mrd_q;

	logic [1:0]                        in_mode;
	logic signed [msk_pkg::DATA_W-1:0] in_value;
	logic                              accept;
	logic                              val_we, min_we;
	logic                              out_load, refused;
	logic [msk_pkg::CNT_W-1:0]         vaddr_cnt, maddr_cnt;
	logic                              m_tvalid_q;
	logic [msk_pkg::OUT_W-1:0]         out_q, out_d;

	assign in_mode  = s_tdata[1:0];
	assign in_value = $signed(s_tdata[33:2]);
	assign s_tready = (state_q == msk_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	always_comb begin
		state_d  = state_q;
		vcnt_d   = vcnt_q;
		mcnt_d   = mcnt_q;
		top_d    = top_q;
		min_d    = min_q;
		val_we   = 1'b0;
		min_we   = 1'b0;
		out_load = 1'b0;
		refused  = 1'b0;
		unique case (state_q)
			msk_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (in_mode)
						msk_pkg::MODE_PUSH: begin
							out_load = 1'b1;
							if (vcnt_q >= msk_pkg::CNT_W'(msk_pkg::STACK_DEPTH)) begin
								refused = 1'b1;
							end else begin
								val_we = 1'b1;
								vcnt_d = vcnt_q + 1'b1;
								top_d  = in_value;
								if ((mcnt_q == '0) || (in_value <= min_q)) begin
									min_we = 1'b1;
									mcnt_d = mcnt_q + 1'b1;
									min_d  = in_value;
								end
							end
						end
						msk_pkg::MODE_POP: begin
							if (vcnt_q != '0) begin
								vcnt_d  = vcnt_q - 1'b1;
								state_d = msk_pkg::ST_LOAD;
								if ((mcnt_q != '0) && (top_q == min_q)) begin
									mcnt_d = mcnt_q - 1'b1;
								end
							end else begin
								out_load = 1'b1;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			msk_pkg::ST_LOAD: begin
				top_d    = $signed(vrd_q);
				min_d    = $signed(mrd_q);
				out_load = 1'b1;
				state_d  = msk_pkg::ST_IDLE;
			end
			default: begin
				state_d = msk_pkg::ST_IDLE;
			end
		endcase
	end

	assign vaddr_cnt = vcnt_d - 1'b1;
	assign maddr_cnt = mcnt_d - 1'b1;

	always_comb begin
		out_d         = '0;
		out_d[31:0]   = (vcnt_d == '0) ? '0 : top_d;
		out_d[63:32]  = (mcnt_d == '0) ? '0 : min_d;
		out_d[64]     = (vcnt_d == '0);
		out_d[65]     = refused;
		out_d[76:66]  = msk_pkg::COUNT_W'(vcnt_d);
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[vcnt_q[msk_pkg::ADDR_W-1:0]] <= in_value;
		end
		if (min_we) begin
			min_mem[mcnt_q[msk_pkg::ADDR_W-1:0]] <= in_value;
		end
		vrd_q <= val_mem[vaddr_cnt[msk_pkg::ADDR_W-1:0]];
		mrd_q <= min_mem[maddr_cnt[msk_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= msk_pkg::ST_IDLE;
			vcnt_q     <= '0;
			mcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vcnt_q  <= vcnt_d;
			mcnt_q  <= mcnt_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		min_q <= min_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

endmodule

// ===== rtl/core/msk_checker.sv =====
// ----------------------------------------------------------------------------
// Minimum-tracking stack port checker
// Watches the top-level ports and checks result consistency over time.
// ----------------------------------------------------------------------------
`include "min_tracking_stack_top_assert.svh"

module msk_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [msk_pkg::OUT_W-1:0]  m_tdata
);

	logic signed [msk_pkg::DATA_W-1:0] out_top;
	logic signed [msk_pkg::DATA_W-1:0] out_min;
	logic                              out_empty;
	logic                              out_refused;
	logic [msk_pkg::COUNT_W-1:0]       out_count;
	logic                              out_full;

	assign out_top     = $signed(m_tdata[31:0]);
	assign out_min     = $signed(m_tdata[63:32]);
	assign out_empty   = m_tdata[64];
	assign out_refused = m_tdata[65];
	assign out_count   = m_tdata[76:66];
	assign out_full    = (out_count == msk_pkg::COUNT_W'(msk_pkg::STACK_DEPTH));

	`MSK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

	`MSK_ASSERT_SAME(a_empty_flag, m_tvalid, out_empty == (out_count == '0), "empty flag mismatch")

	`MSK_ASSERT_SAME(a_empty_zero, m_tvalid && out_empty, (out_top == '0) && (out_min == '0), "empty not zero")

	`MSK_ASSERT_SAME(a_refused_full, m_tvalid && out_refused, out_full, "push refused below full")

	`MSK_ASSERT_SAME(a_min_le_top, m_tvalid && !out_empty, out_min <= out_top, "minimum above top")

endmodule

bind min_tracking_stack_top msk_checker u_msk_checker (.*);
